// ===== src/video_coefficient_vlc_decode_unit_assert.svh =====
// assertion helpers for the coefficient decoder
`ifndef VIDEO_COEFFICIENT_VLC_DECODE_UNIT_ASSERT_SVH
`define VIDEO_COEFFICIENT_VLC_DECODE_UNIT_ASSERT_SVH

`ifndef SYNTH

// property checked only while out of reset
`define VCVD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define VCVD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VCVD_ASSERT(lbl, prop, msg)

`define VCVD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/vcvd_pkg.sv =====
`timescale 1ns / 1ps

package vcvd_pkg;

    // default window width, and the smallest supported
    localparam int WINDOW_BITS_DEF = 20;
    // bits that any single code can span
    localparam int DECODE_SPAN     = 20;

    // result packing
    localparam int OUT_FIELDS_W = 34;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // intra dc and reconstruction constants
    localparam logic [7:0] DC_FORBID_ZERO = 8'h00;
    localparam logic [7:0] DC_FORBID_HALF = 8'h80;
    localparam logic [7:0] DC_MAX_CODE    = 8'hFF;
    localparam logic signed [11:0] DC_MAX_REC = 12'sd1024;
    localparam logic signed [15:0] REC_MIN    = -16'sd2048;
    localparam logic signed [15:0] REC_MAX    = 16'sd2047;

    // escape prefix 000001, left aligned in a 13-bit compare field
    localparam logic [5:0]  ESC_CODE    = 6'b000001;
    localparam logic [12:0] ESC_ALIGNED = 13'b0000010000000;
    localparam logic [4:0]  ESC_USED    = 5'd20;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_NOCODE  = 3'd2,
        ST_FORBID  = 3'd3,
        ST_BADCALL = 3'd4
    } status_t;

    // decoded code before reconstruction
    typedef struct packed {
        status_t            status;
        logic               is_eob;
        logic               is_escape;
        logic [5:0]         run;
        logic signed [7:0]  level;
        logic [4:0]         bits_used;
        logic               is_dc;
        logic [7:0]         dc_val;
    } dec_t;

    // table code without its sign bit
    typedef struct packed {
        logic [7:0] code;
        logic [3:0] len;
        logic [4:0] run;
        logic [3:0] lvl;
    } vlc_entry_t;

    localparam int VLC_N = 62;

    localparam vlc_entry_t VLC_TAB [VLC_N] = '{
        '{8'h04, 4'd4,  5'd0, 4'd2},  '{8'h05, 4'd5,  5'd0, 4'd3},
        '{8'h06, 4'd7,  5'd0, 4'd4},  '{8'h26, 4'd8,  5'd0, 4'd5},
        '{8'h21, 4'd8,  5'd0, 4'd6},  '{8'h0A, 4'd10, 5'd0, 4'd7},
        '{8'h1D, 4'd12, 5'd0, 4'd8},  '{8'h18, 4'd12, 5'd0, 4'd9},
        '{8'h13, 4'd12, 5'd0, 4'd10}, '{8'h10, 4'd12, 5'd0, 4'd11},
        '{8'h1A, 4'd13, 5'd0, 4'd12}, '{8'h19, 4'd13, 5'd0, 4'd13},
        '{8'h18, 4'd13, 5'd0, 4'd14}, '{8'h17, 4'd13, 5'd0, 4'd15},
        '{8'h03, 4'd3,  5'd1, 4'd1},  '{8'h06, 4'd6,  5'd1, 4'd2},
        '{8'h25, 4'd8,  5'd1, 4'd3},  '{8'h0C, 4'd10, 5'd1, 4'd4},
        '{8'h1B, 4'd12, 5'd1, 4'd5},  '{8'h16, 4'd13, 5'd1, 4'd6},
        '{8'h15, 4'd13, 5'd1, 4'd7},
        '{8'h05, 4'd4,  5'd2, 4'd1},  '{8'h04, 4'd7,  5'd2, 4'd2},
        '{8'h0B, 4'd10, 5'd2, 4'd3},  '{8'h14, 4'd12, 5'd2, 4'd4},
        '{8'h14, 4'd13, 5'd2, 4'd5},
        '{8'h07, 4'd5,  5'd3, 4'd1},  '{8'h24, 4'd8,  5'd3, 4'd2},
        '{8'h1C, 4'd12, 5'd3, 4'd3},  '{8'h13, 4'd13, 5'd3, 4'd4},
        '{8'h06, 4'd5,  5'd4, 4'd1},  '{8'h0F, 4'd10, 5'd4, 4'd2},
        '{8'h12, 4'd12, 5'd4, 4'd3},
        '{8'h07, 4'd6,  5'd5, 4'd1},  '{8'h09, 4'd10, 5'd5, 4'd2},
        '{8'h12, 4'd13, 5'd5, 4'd3},
        '{8'h05, 4'd6,  5'd6, 4'd1},  '{8'h1E, 4'd12, 5'd6, 4'd2},
        '{8'h04, 4'd6,  5'd7, 4'd1},  '{8'h15, 4'd12, 5'd7, 4'd2},
        '{8'h07, 4'd7,  5'd8, 4'd1},  '{8'h11, 4'd12, 5'd8, 4'd2},
        '{8'h05, 4'd7,  5'd9, 4'd1},  '{8'h11, 4'd13, 5'd9, 4'd2},
        '{8'h27, 4'd8,  5'd10, 4'd1}, '{8'h10, 4'd13, 5'd10, 4'd2},
        '{8'h23, 4'd8,  5'd11, 4'd1}, '{8'h22, 4'd8,  5'd12, 4'd1},
        '{8'h20, 4'd8,  5'd13, 4'd1},
        '{8'h0E, 4'd10, 5'd14, 4'd1}, '{8'h0D, 4'd10, 5'd15, 4'd1},
        '{8'h08, 4'd10, 5'd16, 4'd1},
        '{8'h1F, 4'd12, 5'd17, 4'd1}, '{8'h1A, 4'd12, 5'd18, 4'd1},
        '{8'h19, 4'd12, 5'd19, 4'd1}, '{8'h17, 4'd12, 5'd20, 4'd1},
        '{8'h16, 4'd12, 5'd21, 4'd1},
        '{8'h1F, 4'd13, 5'd22, 4'd1}, '{8'h1E, 4'd13, 5'd23, 4'd1},
        '{8'h1D, 4'd13, 5'd24, 4'd1}, '{8'h1C, 4'd13, 5'd25, 4'd1},
        '{8'h1B, 4'd13, 5'd26, 4'd1}
    };

endpackage

// ===== src/video_coefficient_vlc_decode_unit.sv =====
`timescale 1ns / 1ps

// Coefficient decoder for the transform-coefficient stream of a block.
// Input channel s_axis_*: one item is a left-aligned window of upcoming
// bits, the count of valid bits, the quantizer (tdata) and the first-
// coefficient and intra-dc flags (tuser). Output channel m_axis_*: one
// result per item with status, run, level, reconstructed value and bits
// consumed (tdata) and the eob and escape flags (tuser).
// An item lands in the input register; the table decode and the
// reconstruction multiply sit between it and the result
// register. Throughput is one item per cycle; the result register and the
// input register advance together, so a new item is taken while a result
// waits as long as the result can move on.
// When m_axis_tready is low the result holds, the input register fills,
// and s_axis_tready drops only once both stages hold an item.
// Reset clears both valid flags; the data registers are not reset.
module video_coefficient_vlc_decode_unit import vcvd_pkg::*;
#(
    parameter  int WINDOW_BITS = WINDOW_BITS_DEF,
    localparam int VALID_W     = $clog2(WINDOW_BITS + 1),
    localparam int IN_DATA_W   = ((WINDOW_BITS + VALID_W + 5 + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bit_window, bits_valid, quant, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // first_coeff, intra_dc
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, run, level, rec_level, bits_used, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // is_eob, is_escape
    output logic [1:0]            m_axis_tuser
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [WINDOW_BITS-1:0] in_window_reg;
    logic [VALID_W-1:0]     in_bits_valid_reg;
    logic                   in_first_reg;
    logic                   in_dc_reg;
    logic [4:0]             in_quant_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    dec_t                   out_dec_reg;
    logic signed [11:0]     out_rec_reg;

    logic                   out_load;
    logic                   in_load;
    logic [4:0]             valid_clamped;
    dec_t                   dec;
    logic signed [11:0]     rec_level;

    // pipeline flow control
    assign out_load       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready  = !in_valid_reg || out_load;
    assign in_load        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_window_reg     <= s_axis_tdata[WINDOW_BITS-1:0];
            in_bits_valid_reg <= s_axis_tdata[WINDOW_BITS +: VALID_W];
            in_quant_reg      <= s_axis_tdata[WINDOW_BITS + VALID_W +: 5];
            in_first_reg      <= s_axis_tuser[0];
            in_dc_reg         <= s_axis_tuser[1];
        end
    end

    // counts past the longest code all behave alike
    assign valid_clamped = (in_bits_valid_reg > VALID_W'(DECODE_SPAN))
                           ? 5'(DECODE_SPAN) : 5'(in_bits_valid_reg);

    vcvd_vlc_lookup u_lookup
    (
        .win         (in_window_reg[WINDOW_BITS-1 -: DECODE_SPAN]),
        .valid       (valid_clamped),
        .first_coeff (in_first_reg),
        .intra_dc    (in_dc_reg),
        .quant       (in_quant_reg),
        .dec         (dec)
    );

    vcvd_recon u_recon
    (
        .dec       (dec),
        .quant     (in_quant_reg),
        .rec_level (rec_level)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_dec_reg <= dec;
            out_rec_reg <= rec_level;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                            out_dec_reg.bits_used,
                            out_rec_reg,
                            out_dec_reg.level,
                            out_dec_reg.run,
                            out_dec_reg.status};
    assign m_axis_tuser  = {out_dec_reg.is_escape, out_dec_reg.is_eob};

    // checks
    `include "video_coefficient_vlc_decode_unit_assert.svh"

    `VCVD_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !m_axis_tvalid && s_axis_tready, "pipeline not empty in reset")
    `VCVD_ASSERT(a_advance, in_valid_reg && out_load |=> m_axis_tvalid, "decoded item lost between stages")
    `VCVD_ASSERT(a_err_zero, m_axis_tvalid && out_dec_reg.status != ST_OK |-> out_dec_reg.bits_used == 5'd0 && out_rec_reg == 12'sd0 && !out_dec_reg.is_eob, "error result carries data")
    `VCVD_ASSERT(a_ok_used, m_axis_tvalid && out_dec_reg.status == ST_OK |-> out_dec_reg.bits_used != 5'd0, "ok result consumed no bits")
    `VCVD_ASSERT(a_eob_shape, m_axis_tvalid && out_dec_reg.is_eob |-> out_dec_reg.bits_used == 5'd2 && out_rec_reg == 12'sd0 && !out_dec_reg.is_escape, "malformed eob result")

endmodule

// ===== src/vcvd_vlc_lookup.sv =====
`timescale 1ns / 1ps

module vcvd_vlc_lookup import vcvd_pkg::*;
(
    input  logic [DECODE_SPAN-1:0] win,
    input  logic [4:0]             valid,
    input  logic                   first_coeff,
    input  logic                   intra_dc,
    input  logic [4:0]             quant,
    output dec_t                   dec
);

    always_comb
    begin
        logic [12:0] top13;
        logic [13:0] top14;
        logic [12:0] aligned;
        logic [12:0] mask;
        logic [3:0]  m;
        logic [7:0]  lvl8;
        logic        found;
        logic        agree;

        top13   = win[DECODE_SPAN-1 -: 13];
        top14   = win[DECODE_SPAN-1 -: 14];
        aligned = '0;
        mask    = '0;
        m       = '0;
        lvl8    = '0;
        found   = 1'b0;
        agree   = 1'b0;
        dec     = '0;

        if (intra_dc)
        begin
            // fixed 8-bit dc code, only legal as first coefficient with no quantizer
            if (!first_coeff || quant != 5'd0)
                dec.status = ST_BADCALL;
            else if (valid < 5'd8)
                dec.status = ST_SHORT;
            else if (win[DECODE_SPAN-1 -: 8] == DC_FORBID_ZERO ||
                     win[DECODE_SPAN-1 -: 8] == DC_FORBID_HALF)
                dec.status = ST_FORBID;
            else
            begin
                dec.is_dc     = 1'b1;
                dec.dc_val    = win[DECODE_SPAN-1 -: 8];
                dec.bits_used = 5'd8;
            end
        end
        else if (quant == 5'd0)
            dec.status = ST_BADCALL;
        else if (valid == 5'd0)
            dec.status = ST_SHORT;
        else if (top13[12])
        begin
            // codes starting with 1: first-coefficient 1s, eob 10, or 11s
            if (valid < 5'd2)
                dec.status = ST_SHORT;
            else if (first_coeff)
            begin
                dec.level     = top13[11] ? -8'sd1 : 8'sd1;
                dec.bits_used = 5'd2;
            end
            else if (!top13[11])
            begin
                dec.is_eob    = 1'b1;
                dec.bits_used = 5'd2;
            end
            else if (valid < 5'd3)
                dec.status = ST_SHORT;
            else
            begin
                dec.level     = top13[10] ? -8'sd1 : 8'sd1;
                dec.bits_used = 5'd3;
            end
        end
        else
        begin
            // full table match including the sign bit
            for (int i = 0; i < VLC_N; i++)
            begin
                aligned = 13'(VLC_TAB[i].code) << (4'd13 - VLC_TAB[i].len);
                mask    = ~(13'h1FFF >> VLC_TAB[i].len);
                if (!found && valid >= ({1'b0, VLC_TAB[i].len} + 5'd1) &&
                    ((top13 ^ aligned) & mask) == 13'd0)
                begin
                    found         = 1'b1;
                    lvl8          = {4'd0, VLC_TAB[i].lvl};
                    dec.run       = {1'b0, VLC_TAB[i].run};
                    dec.level     = top14[4'd13 - VLC_TAB[i].len] ? (8'd0 - lvl8) : lvl8;
                    dec.bits_used = {1'b0, VLC_TAB[i].len} + 5'd1;
                end
            end

            if (!found)
            begin
                if (valid >= 5'd6 && top13[12:7] == ESC_CODE)
                begin
                    // escape: 6-bit run then 8-bit level
                    if (valid < ESC_USED)
                        dec.status = ST_SHORT;
                    else if (win[7:0] == DC_FORBID_ZERO || win[7:0] == DC_FORBID_HALF)
                        dec.status = ST_FORBID;
                    else
                    begin
                        dec.is_escape = 1'b1;
                        dec.run       = win[13:8];
                        dec.level     = win[7:0];
                        dec.bits_used = ESC_USED;
                    end
                end
                else
                begin
                    // short window if the valid prefix agrees with any code
                    m    = (valid < 5'd6) ? valid[3:0] : 4'd6;
                    mask = ~(13'h1FFF >> m);
                    if (((top13 ^ ESC_ALIGNED) & mask) == 13'd0)
                        agree = 1'b1;
                    for (int i = 0; i < VLC_N; i++)
                    begin
                        m       = (valid < {1'b0, VLC_TAB[i].len}) ? valid[3:0]
                                                                   : VLC_TAB[i].len;
                        aligned = 13'(VLC_TAB[i].code) << (4'd13 - VLC_TAB[i].len);
                        mask    = ~(13'h1FFF >> m);
                        if (((top13 ^ aligned) & mask) == 13'd0)
                            agree = 1'b1;
                    end
                    dec.status = agree ? ST_SHORT : ST_NOCODE;
                end
            end
        end
    end

endmodule

// ===== src/vcvd_recon.sv =====
`timescale 1ns / 1ps

module vcvd_recon import vcvd_pkg::*;
(
    input  dec_t               dec,
    input  logic [4:0]         quant,
    output logic signed [11:0] rec_level
);

    always_comb
    begin
        logic signed [9:0]  lvl10;
        logic signed [9:0]  odd_t;
        logic signed [5:0]  q_s;
        logic signed [15:0] prod;
        logic signed [11:0] clipped;
        logic               pos;

        lvl10 = {{2{dec.level[7]}}, dec.level};
        pos   = !dec.level[7] && (dec.level != 8'sd0);
        q_s   = $signed({1'b0, quant});

        // q * (2L +/- 1), pulled toward zero by one for even q
        odd_t = pos ? ((lvl10 <<< 1) + 10'sd1) : ((lvl10 <<< 1) - 10'sd1);
        prod  = 16'(q_s) * 16'(odd_t);
        if (!quant[0])
            prod = pos ? (prod - 16'sd1) : (prod + 16'sd1);

        // clip to the 12-bit coefficient range
        if (prod < REC_MIN)
            clipped = REC_MIN[11:0];
        else if (prod > REC_MAX)
            clipped = REC_MAX[11:0];
        else
            clipped = prod[11:0];

        if (dec.status != ST_OK || dec.is_eob)
            rec_level = 12'sd0;
        else if (dec.is_dc)
            rec_level = (dec.dc_val == DC_MAX_CODE) ? DC_MAX_REC
                                                    : $signed({1'b0, dec.dc_val, 3'b000});
        else
            rec_level = clipped;
    end

endmodule
